// ===== rtl/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  // Field widths of the transfer payloads.
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 5;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 48;
  localparam int LEN_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // Input transfer payload.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] entry_index;
    logic [BYTE_W-1:0]  entry_value;
    logic               entry_care;
    logic [BYTE_W-1:0]  data_byte;
    logic [ADDR_W-1:0]  data_address;
    logic               last_byte;
  } in_item_t;

  // Result transfer payload.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  // Controls from the scan sequencer to the matcher.
  typedef struct packed {
    logic load;     // write one pattern entry
    logic restart;  // clear partial matches for a new scan
    logic step;     // compare one data byte
    logic gap;      // address gap: drop partial matches before comparing
  } match_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wbps_matcher.sv =====
// ----------------------------------------------------------------------------
// wbps_matcher
// Pattern entry store and shift-and partial match vector. Compares one data
// byte against every pattern entry in parallel and flags a complete match.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wbps_pkg::match_ctl_t        ctl,
  input  wire logic [wbps_pkg::INDEX_W-1:0] entry_index,
  input  wire logic [wbps_pkg::BYTE_W-1:0]  entry_value,
  input  wire logic                        entry_care,
  input  wire logic [wbps_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic [wbps_pkg::LEN_W-1:0]   len,
  output logic                             tail_hit
);

  // Only the first 32 entries can be loaded; later positions act as wildcards.
  localparam int ENTRIES = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
  // The pattern length register cannot exceed 63.
  localparam int MATCH_W = (PATTERN_MAX < 63) ? PATTERN_MAX : 63;

  logic [wbps_pkg::BYTE_W-1:0] pat_byte_r [ENTRIES];
  logic                        pat_care_r [ENTRIES];
  logic [MATCH_W-1:0]          pm_r;
  logic [MATCH_W-1:0]          pm_nxt;
  logic [MATCH_W-1:0]          pm_eff;
  logic [MATCH_W-1:0]          pm_new;
  logic [MATCH_W-1:0]          eq;
  logic [MATCH_W-1:0]          tail_sel;

  // Pattern entry writes.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (ctl.load && (5'(k) == entry_index)) begin
        pat_byte_r[k] <= entry_value;
        pat_care_r[k] <= entry_care;
      end
    end
  end

  // Per-position byte compare.
  for (genvar k = 0; k < MATCH_W; k++) begin : g_cmp
    if (k < ENTRIES) begin : g_real
      assign eq[k] = !pat_care_r[k] || (pat_byte_r[k] == data_byte);
    end else begin : g_wild
      assign eq[k] = 1'b1;
    end
  end

  assign pm_eff = ctl.gap ? '0 : pm_r;

  // Shift-and update: position k extends the match of position k-1.
  for (genvar k = 0; k < MATCH_W; k++) begin : g_shift
    if (k == 0) begin : g_head
      assign pm_new[k] = (7'(k) < {1'b0, len}) && eq[k];
    end else begin : g_body
      assign pm_new[k] = (7'(k) < {1'b0, len}) && pm_eff[k-1] && eq[k];
    end
    assign tail_sel[k] = (7'(k + 1) == {1'b0, len});
  end

  // An empty pattern matches at every byte.
  assign tail_hit = (len == '0) || (|(pm_new & tail_sel));

  always_comb begin
    pm_nxt = pm_r;
    if (ctl.restart) begin
      pm_nxt = '0;
    end else if (ctl.step) begin
      pm_nxt = (len == '0) ? pm_eff : pm_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= '0;
    end else begin
      pm_r <= pm_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scan_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_unit
// Scans a stream of addressed bytes for a wildcard byte pattern and reports
// the first match that starts inside the configured address range.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle and keeps that rate as long as the
// result side does not stall. An accepted item lands in an input register and
// is processed as it leaves that slot: the data byte is compared against all
// pattern entries at once and the shift-and partial match vector is updated,
// and a result is written into the output register at that same clock edge,
// from which it transfers when the result side does not stall.
// Items that produce no result still move through the same slot and wait
// only while a stalled result is held in the output register. Pattern entries
// are loaded with load items, a start item begins a new scan, and after a
// found or not-found report data items are ignored until the next start item.
`default_nettype none

module wildcard_byte_pattern_scan_unit #(
  parameter int PATTERN_MAX  = 32,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire wbps_pkg::in_item_t              in_item,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output wbps_pkg::out_item_t                  out_item
);

  localparam int AW_EFF = (ADDRESS_BITS < wbps_pkg::ADDR_W) ? ADDRESS_BITS : wbps_pkg::ADDR_W;
  localparam logic [wbps_pkg::ADDR_W-1:0] ADDR_MASK =
    {wbps_pkg::ADDR_W{1'b1}} >> (wbps_pkg::ADDR_W - AW_EFF);
  localparam int LEN_MAX = (PATTERN_MAX < 63) ? PATTERN_MAX : 63;
  localparam logic [wbps_pkg::LEN_W-1:0] LEN_LIMIT = wbps_pkg::LEN_W'(LEN_MAX);

  logic [wbps_pkg::ADDR_W-1:0] range_lo_r;
  logic [wbps_pkg::ADDR_W-1:0] range_len_r;
  logic [wbps_pkg::ADDR_W-1:0] range_hi_r;
  logic [wbps_pkg::LEN_W-1:0]  pat_len_r;
  logic [wbps_pkg::ADDR_W-1:0] cfg_masked;
  logic [wbps_pkg::ADDR_W-1:0] sat_lo;
  logic [wbps_pkg::ADDR_W-1:0] sat_len;
  logic [wbps_pkg::ADDR_W-1:0] sat_end;

  wbps_pkg::in_item_t   item_r;
  logic                 item_valid_r;
  logic                 item_valid_nxt;
  wbps_pkg::out_item_t  out_r;
  wbps_pkg::out_item_t  out_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  logic [wbps_pkg::ADDR_W-1:0] prev_addr_r;
  logic [wbps_pkg::ADDR_W-1:0] prev_addr_nxt;
  logic                        prev_valid_r;
  logic                        prev_valid_nxt;
  logic                        done_r;
  logic                        done_nxt;

  logic                        in_accept;
  logic                        advance;
  logic                        emit;
  logic                        data_step;
  logic [wbps_pkg::ADDR_W-1:0] addr;
  logic [wbps_pkg::LEN_W-1:0]  len_eff;
  logic [wbps_pkg::LEN_W-1:0]  len_back;
  logic [wbps_pkg::ADDR_W-1:0] start_addr;
  logic                        start_in_range;
  logic                        tail_hit;
  logic                        hit;
  wbps_pkg::match_ctl_t        ctl;

  // Configuration: keep the masked range start and a saturated range end.
  assign cfg_masked = cfg_wdata & ADDR_MASK;
  assign sat_lo  = (cfg_index == wbps_pkg::CFG_RANGE_START)  ? cfg_masked : range_lo_r;
  assign sat_len = (cfg_index == wbps_pkg::CFG_RANGE_LENGTH) ? cfg_masked : range_len_r;
  assign sat_end = (sat_len > (ADDR_MASK - sat_lo)) ? ADDR_MASK : (sat_lo + sat_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_lo_r  <= '0;
      range_len_r <= '0;
      range_hi_r  <= '0;
      pat_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::CFG_RANGE_START: begin
          range_lo_r <= cfg_masked;
          range_hi_r <= sat_end;
        end
        wbps_pkg::CFG_RANGE_LENGTH: begin
          range_len_r <= cfg_masked;
          range_hi_r  <= sat_end;
        end
        wbps_pkg::CFG_PATTERN_LENGTH: begin
          pat_len_r <= cfg_wdata[wbps_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: the slot moves on whenever the output register can take
  // a possible result.
  assign advance   = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_item;
    end
  end

  // Scan control for the item in the slot.
  assign data_step = advance && (item_r.mode == wbps_pkg::MODE_DATA) && !done_r;
  assign addr      = item_r.data_address & ADDR_MASK;
  assign len_eff   = (pat_len_r > LEN_LIMIT) ? LEN_LIMIT : pat_len_r;

  assign ctl.load    = advance && (item_r.mode == wbps_pkg::MODE_LOAD);
  assign ctl.restart = advance && (item_r.mode == wbps_pkg::MODE_START);
  assign ctl.step    = data_step;
  assign ctl.gap     = prev_valid_r && (addr != ((prev_addr_r + 1'b1) & ADDR_MASK));

  wbps_matcher #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_matcher (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .entry_index (item_r.entry_index),
    .entry_value (item_r.entry_value),
    .entry_care  (item_r.entry_care),
    .data_byte   (item_r.data_byte),
    .len         (len_eff),
    .tail_hit    (tail_hit)
  );

  // Match start address and range check.
  assign len_back       = (len_eff == '0) ? '0 : (len_eff - 1'b1);
  assign start_addr     = (addr - {{(wbps_pkg::ADDR_W-wbps_pkg::LEN_W){1'b0}}, len_back})
                          & ADDR_MASK;
  assign start_in_range = (start_addr >= range_lo_r) && (start_addr < range_hi_r);
  assign hit            = tail_hit && start_in_range;
  assign emit           = data_step && (hit || item_r.last_byte);

  // Scan state updates.
  always_comb begin
    prev_addr_nxt  = prev_addr_r;
    prev_valid_nxt = prev_valid_r;
    done_nxt       = done_r;
    if (ctl.restart) begin
      prev_addr_nxt  = '0;
      prev_valid_nxt = 1'b0;
      done_nxt       = 1'b0;
    end else if (data_step) begin
      prev_addr_nxt  = addr;
      prev_valid_nxt = 1'b1;
      done_nxt       = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_addr_r  <= '0;
      prev_valid_r <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      prev_addr_r  <= prev_addr_nxt;
      prev_valid_r <= prev_valid_nxt;
      done_r       <= done_nxt;
    end
  end

  // Result register.
  always_comb begin
    out_nxt.found         = hit;
    out_nxt.match_address = hit ? start_addr : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A not-found report always carries a zero address.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.match_address == '0))
    else $error("not-found result with nonzero address");

  // Any report ends the scan until the next start item.
  a_report_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> done_r)
    else $error("scan not marked done after a report");

  // The input side only stalls while an item is held in the slot.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |-> !in_stall)
    else $error("input stalled with an empty slot");

endmodule

`default_nettype wire

// ===== tb/scan_report_check.sv =====
// ----------------------------------------------------------------------------
// scan_report_check
// Watches the configuration port and both transfer channels of the wildcard
// byte pattern scan unit. It keeps its own copy of the pattern, the range and
// the shift-and match state, predicts the report of every accepted item and
// compares each accepted result with the oldest pending report, field by
// field.
// ----------------------------------------------------------------------------
module scan_report_check
  import wbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  output int                    mismatches,
  output int                    open_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

  // Copy of the configuration registers.
  logic [ADDR_W-1:0] win_start;
  logic [ADDR_W-1:0] win_length;
  logic [LEN_W-1:0]  pat_len;

  // Copy of the scan state.
  logic [BYTE_W-1:0]      pat_value [PATTERN_MAX];
  logic                   pat_care  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] partial;
  logic [ADDR_W-1:0]      prev_addr;
  logic                   prev_valid;
  logic                   scan_done;

  // Reports predicted but not yet seen on the result channel.
  out_item_t pending_reports [$];
  int        fail_count = 0;
  int        pending_count = 0;

  assign mismatches   = fail_count;
  assign open_reports = pending_count;

  task automatic flag_mismatch(input string what);
    $display("%0t report check: %s", $realtime, what);
    fail_count++;
  endtask

  // A match may start in [start, start + length), with the end saturating at
  // the largest address, which therefore never starts a match.
  function automatic logic in_window(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] lim;
    if (win_length > ADDR_TOP - win_start) lim = ADDR_TOP;
    else lim = win_start + win_length;
    return (a >= win_start) && (a < lim);
  endfunction

  // Applies one accepted item to the state and queues the report it causes.
  function automatic void predict_scan_step(input in_item_t it);
    int                     eff;
    logic [PATTERN_MAX-1:0] chain;
    logic [PATTERN_MAX-1:0] next_vec;
    logic [ADDR_W-1:0]      next_addr;
    logic [ADDR_W-1:0]      start_addr;
    logic                   hit;
    out_item_t              rep;
    case (it.mode)
      MODE_LOAD: begin
        pat_value[it.entry_index] = it.entry_value;
        pat_care[it.entry_index]  = it.entry_care;
      end
      MODE_START: begin
        partial    = '0;
        prev_valid = 1'b0;
        prev_addr  = '0;
        scan_done  = 1'b0;
      end
      MODE_DATA: begin
        if (!scan_done) begin
          eff = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
          // A break in the address sequence drops every partial match.
          next_addr = prev_addr + 1'b1;
          if (prev_valid && it.data_address != next_addr) partial = '0;
          prev_addr  = it.data_address;
          prev_valid = 1'b1;
          if (eff == 0) begin
            start_addr = it.data_address;
            hit = in_window(start_addr);
          end else begin
            // Entry k extends the partial match that ended at entry k-1.
            chain = {partial[PATTERN_MAX-2:0], 1'b1};
            for (int k = 0; k < PATTERN_MAX; k++) begin
              next_vec[k] = (k < eff) && chain[k] &&
                            (!pat_care[k] || pat_value[k] == it.data_byte);
            end
            partial    = next_vec;
            start_addr = it.data_address - ADDR_W'(eff - 1);
            hit = partial[eff-1] && in_window(start_addr);
          end
          if (hit) begin
            rep.found         = 1'b1;
            rep.match_address = start_addr;
            pending_reports.push_back(rep);
            scan_done = 1'b1;
          end else if (it.last_byte) begin
            rep.found         = 1'b0;
            rep.match_address = '0;
            pending_reports.push_back(rep);
            scan_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch($sformatf("result with none pending: found=%0b addr=%h",
                              got.found, got.match_address));
    end else begin
      want = pending_reports.pop_front();
      if (got.found !== want.found)
        flag_mismatch($sformatf("found is %b, expected %b", got.found, want.found));
      if (got.match_address !== want.match_address)
        flag_mismatch($sformatf("match_address is %h, expected %h",
                                got.match_address, want.match_address));
    end
  endtask

  // Everything is sampled at the rising edge, before the unit updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      win_start  = '0;
      win_length = '0;
      pat_len    = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        pat_value[k] = '0;
        pat_care[k]  = 1'b0;
      end
      partial    = '0;
      prev_addr  = '0;
      prev_valid = 1'b0;
      scan_done  = 1'b0;
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_START:    win_start  = cfg_wdata[ADDR_W-1:0];
          CFG_RANGE_LENGTH:   win_length = cfg_wdata[ADDR_W-1:0];
          CFG_PATTERN_LENGTH: pat_len    = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_scan_step(in_item);
      if (out_valid && !out_stall) check_report(out_item);
    end
    pending_count = pending_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the wildcard byte pattern scan unit. A short
// directed part covers the empty pattern, address wrap, the largest address,
// wildcards, gaps, matches outside the range and on the last byte. Random
// phases then change the range and pattern length, load patterns and run
// scans with embedded matches, gaps and stray items, while both sides idle
// and stall at random. The report check module does all the comparing.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam int PATTERN_MAX   = 32;
  localparam int ITEM_TARGET   = 1950;
  localparam int QUIET_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_W        = $bits(in_item_t);
  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};
  // The unit ignores this mode.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  int                    mismatches;
  int                    open_reports;

  // Idling control shared by the sender and the receiver.
  bit          quiet_tail = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_served = 1'b0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  int unsigned tx_free_left = 0;
  int unsigned cycles = 0;
  int          sent = 0;

  // What the stimulus knows of the loaded pattern and the current phase.
  logic [BYTE_W-1:0] pat_value [PATTERN_MAX];
  logic              pat_care  [PATTERN_MAX];
  logic [BYTE_W-1:0] byte_pool [4];
  logic [ADDR_W-1:0] phase_base;
  int                eff_len = 0;

  wildcard_byte_pattern_scan_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  scan_report_check #(.PATTERN_MAX(PATTERN_MAX)) u_report_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .open_reports (open_reports)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit for a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, free stretches, and one long hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_tail) begin
          if (free_left > 0) free_left--;
          else if ($urandom_range(0, 11) == 0) free_left = $urandom_range(20, 80);
          else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 7);
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // An item with every field random except the mode.
  function automatic in_item_t make_item(input logic [MODE_W-1:0] mode);
    in_item_t           it;
    logic [ITEM_W-1:0]  raw;
    raw = ITEM_W'({$urandom(), $urandom(), $urandom()});
    it = raw;
    it.mode = mode;
    return it;
  endfunction

  function automatic logic [BYTE_W-1:0] pool_byte();
    if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom());
    return byte_pool[$urandom_range(0, 3)];
  endfunction

  // Offers one item and holds it until the transfer happens.
  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail) begin
      if (tx_free_left > 0) tx_free_left--;
      else if ($urandom_range(0, 11) == 0) tx_free_left = $urandom_range(20, 80);
      else if ($urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_load(input int idx, input logic [BYTE_W-1:0] val, input logic care);
    in_item_t it;
    it = make_item(MODE_LOAD);
    it.entry_index = INDEX_W'(idx);
    it.entry_value = val;
    it.entry_care  = care;
    pat_value[idx] = val;
    pat_care[idx]  = care;
    send(it);
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] val, input logic [ADDR_W-1:0] addr,
                           input logic last);
    in_item_t it;
    it = make_item(MODE_DATA);
    it.data_byte    = val;
    it.data_address = addr;
    it.last_byte    = last;
    send(it);
  endtask

  // Stops sending until every predicted report has arrived, then lets the
  // pipeline drain items that cause no report.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_reports != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic write_config(input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] rl,
                              input int plen);
    write_reg(CFG_RANGE_START, rs);
    write_reg(CFG_RANGE_LENGTH, rl);
    write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    @(negedge clk);
    cfg_we <= 1'b0;
    eff_len = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
  endtask

  function automatic int pick_length();
    int plen;
    case ($urandom_range(0, 9))
      0:       plen = 0;
      1:       plen = 1;
      2:       plen = PATTERN_MAX;
      3:       plen = $urandom_range(PATTERN_MAX + 1, 63);
      4:       plen = $urandom_range(9, PATTERN_MAX - 1);
      default: plen = $urandom_range(2, 8);
    endcase
    return plen;
  endfunction

  // One scan: a start item, then ascending bytes that may hold the pattern,
  // with gaps, stray items and pattern rewrites mixed in.
  task automatic run_scan();
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data_val;
    logic              last;
    int                n;
    int                embed_at;
    addr = phase_base + $urandom_range(0, 100);
    n = $urandom_range(3, 30) + eff_len;
    embed_at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, n - eff_len) : -1;
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_req   = 1'b1;
    end
    send(make_item(MODE_START));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 39))
        0: send(make_item(MODE_UNUSED));
        1: send(make_item(MODE_W'($urandom_range(0, 3))));
        2: send_load($urandom_range(0, PATTERN_MAX - 1), pool_byte(), 1'($urandom_range(0, 1)));
        3: addr = addr + $urandom_range(2, 300);
        4: addr = rand_addr();
        default: ;
      endcase
      if (embed_at >= 0 && i >= embed_at && i < embed_at + eff_len &&
          pat_care[i - embed_at])
        data_val = pat_value[i - embed_at];
      else
        data_val = pool_byte();
      last = (i == n - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 59) == 0);
      send_data(data_val, addr, last);
      addr = addr + 1'b1;
    end
  endtask

  // A phase sets the range and pattern length, loads a pattern and runs a
  // few scans around one base address.
  task automatic run_phase(input int plen, input int window_kind, input int base_kind);
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] rl;
    case (base_kind)
      0:       phase_base = rand_addr();
      1:       phase_base = ADDR_W'($urandom_range(0, 40));
      default: phase_base = ADDR_TOP - $urandom_range(0, 140);
    endcase
    case (window_kind)
      0: begin rs = '0; rl = ADDR_TOP; end
      1: begin rs = phase_base + $urandom_range(0, 60); rl = ADDR_W'($urandom_range(1, 120)); end
      2: begin rs = phase_base + $urandom_range(0, 60); rl = ADDR_TOP; end
      3: begin rs = phase_base; rl = '0; end
      4: begin rs = ADDR_TOP; rl = rand_addr(); end
      default: begin rs = rand_addr(); rl = rand_addr(); end
    endcase
    settle();
    write_config(rs, rl, plen);
    for (int k = 0; k < 4; k++) byte_pool[k] = BYTE_W'($urandom());
    for (int k = 0; k < eff_len; k++) send_load(k, pool_byte(), $urandom_range(0, 3) != 0);
    repeat ($urandom_range(2, 5)) run_scan();
  endtask

  initial begin
    int rand_from;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty pattern over the whole range: the largest address cannot start a
    // match, the wrap to zero does, and later items are ignored.
    write_config('0, ADDR_TOP, 0);
    send(make_item(MODE_START));
    send_data(8'h00, ADDR_TOP, 1'b0);
    send_data(8'hFF, '0, 1'b0);
    send_data(8'h5A, 48'h1, 1'b1);
    send(make_item(MODE_UNUSED));

    // Three entries with a wildcard in the middle, range 0x100 to 0x103.
    settle();
    write_config(48'h100, 48'h4, 3);
    send_load(0, 8'h41, 1'b1);
    send_load(1, 8'hA5, 1'b0);
    send_load(2, 8'hFF, 1'b1);
    send(make_item(MODE_START));
    // Match that starts below the range.
    send_data(8'h41, 48'h0FE, 1'b0);
    send_data(8'h12, 48'h0FF, 1'b0);
    send_data(8'hFF, 48'h100, 1'b0);
    // A gap breaks this one.
    send_data(8'h41, 48'h101, 1'b0);
    send_data(8'h34, 48'h102, 1'b0);
    send_data(8'hFF, 48'h105, 1'b0);
    // Jump back and match inside the range.
    send_data(8'h41, 48'h102, 1'b0);
    send_data(8'h00, 48'h103, 1'b0);
    send_data(8'hFF, 48'h104, 1'b0);
    // Match completed by the last byte, then a scan with no match.
    send(make_item(MODE_START));
    send_data(8'h41, 48'h100, 1'b0);
    send_data(8'h99, 48'h101, 1'b0);
    send_data(8'hFF, 48'h102, 1'b1);
    send(make_item(MODE_START));
    send_data(8'h41, 48'h200, 1'b1);

    // Random phases: oversized length with a saturating range near the top,
    // a full-length pattern near zero, then the long result hold-off.
    rand_from = sent;
    run_phase(63, 2, 2);
    run_phase(PATTERN_MAX, 0, 1);
    hold_armed = 1'b1;
    run_phase(4, 1, 0);
    while (sent - rand_from < ITEM_TARGET) begin
      if (sent - rand_from >= ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
      run_phase(pick_length(), $urandom_range(0, 5), $urandom_range(0, 2));
    end
    settle();

    if (mismatches == 0 && open_reports == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wbps_pkg.sv
rtl/wbps_matcher.sv
rtl/wildcard_byte_pattern_scan_unit.sv
tb/scan_report_check.sv
tb/tb.sv
